// ----- rtl/core/srs_pkg.sv -----
`timescale 1ns / 1ps

package srs_pkg;

	localparam int OFFSET_W   = 48;
	localparam int LENGTH_W   = 32;
	localparam int KIB_W      = 21;
	localparam int WIDTH_W    = 5;
	localparam int KIB_SHIFT  = 10;
	localparam int DIVIDEND_W = OFFSET_W - KIB_SHIFT;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
	localparam int OBJ_OFF_W  = 30;
	localparam int CHUNK_W    = 31;
	localparam int TARGET_W   = 4;
	localparam int MAX_CHUNKS = 64;
	localparam int CHUNK_CNT_W = 6;
	localparam int MAX_TARGETS = 16;
	localparam logic [KIB_W-1:0] KIB_MAX   = KIB_W'(1048576);
	localparam logic [KIB_W-1:0] KIB_RESET = KIB_W'(128);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1);

	localparam logic REG_STRIPE_KIB   = 1'b0;
	localparam logic REG_STRIPE_WIDTH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_OBJ,
		ST_DIV_TGT,
		ST_EMIT
	} srs_state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [KIB_W-1:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [KIB_W-1:0]      remainder;
	} div_rsp_t;

endpackage

// ----- rtl/core/srs_div.sv -----
`timescale 1ns / 1ps

module srs_div import srs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [KIB_W-1:0]      rem_q;
	logic [KIB_W-1:0]      divisor_q;
	logic [KIB_W:0]        trial;
	logic [KIB_W:0]        diff;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ~diff[KIB_W]};
			rem_q <= diff[KIB_W] ? trial[KIB_W-1:0] : diff[KIB_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- rtl/core/stripe_request_splitter_top.sv -----
`timescale 1ns / 1ps

// channel | handshake              | payload
// --------+------------------------+--------------------------------------------
// in      | in_valid / in_stall    | req_offset, req_length
// out     | out_valid / out_stall  | object_index, offset_in_object, chunk_bytes,
//         |                        | target_index, bytes_done, last_chunk, truncated
// cfg     | cfg_we                 | cfg_index, cfg_wdata
//
// A request runs two passes of one bit-serial divider (38 steps each): offset by
// stripe size, then object number by width. After the second pass the first
// chunk is ready, then one chunk per cycle while out_stall is low.
// A zero-length request is taken and gives no beat. in_stall is high from acceptance
// until the last chunk has been loaded into the output register.
// arst_n restores stripe_kib to 128 and stripe_width to 1.

module stripe_request_splitter_top import srs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OFFSET_W-1:0]   req_offset,
	input  logic [LENGTH_W-1:0]   req_length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OFFSET_W-1:0]   object_index,
	output logic [OBJ_OFF_W-1:0]  offset_in_object,
	output logic [CHUNK_W-1:0]    chunk_bytes,
	output logic [TARGET_W-1:0]   target_index,
	output logic [LENGTH_W-1:0]   bytes_done,
	output logic                  last_chunk,
	output logic                  truncated,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [KIB_W-1:0]      cfg_wdata
);

	srs_state_t state_q, state_d;

	logic [KIB_W-1:0]       kib_q;
	logic [WIDTH_W-1:0]     width_q;
	logic [KIB_W-1:0]       kib_eff;
	logic [WIDTH_W-1:0]     width_eff;
	logic [CHUNK_W-1:0]     stripe_bytes;

	div_req_t               div_req;
	div_rsp_t               div_rsp;

	logic [KIB_SHIFT-1:0]   lo_q;
	logic [LENGTH_W-1:0]    len_q;
	logic [LENGTH_W-1:0]    rem_q;
	logic [OFFSET_W-1:0]    obj_q;
	logic [OBJ_OFF_W-1:0]   off_q;
	logic [TARGET_W-1:0]    tgt_q;
	logic [CHUNK_CNT_W-1:0] cnt_q;

	logic                   out_valid_q;
	logic [OFFSET_W-1:0]    obj_out_q;
	logic [OBJ_OFF_W-1:0]   off_out_q;
	logic [CHUNK_W-1:0]     size_out_q;
	logic [TARGET_W-1:0]    tgt_out_q;
	logic [LENGTH_W-1:0]    done_out_q;
	logic                   last_out_q;
	logic                   cut_out_q;

	logic                   in_take;
	logic                   emit;
	logic [CHUNK_W-1:0]     room;
	logic [CHUNK_W-1:0]     size;
	logic [LENGTH_W-1:0]    rem_next;
	logic                   cut;
	logic                   last;

	assign kib_eff   = (kib_q == '0) ? KIB_W'(1) : ((kib_q > KIB_MAX) ? KIB_MAX : kib_q);
	assign width_eff = (width_q == '0) ? WIDTH_W'(1) :
	                   ((width_q > WIDTH_W'(MAX_TARGETS)) ? WIDTH_W'(MAX_TARGETS) : width_q);
	assign stripe_bytes = {kib_eff[CHUNK_W-KIB_SHIFT-1:0], {KIB_SHIFT{1'b0}}};

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign emit     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign room     = stripe_bytes - CHUNK_W'(off_q);
	assign size     = (rem_q < {1'b0, room}) ? rem_q[CHUNK_W-1:0] : room;
	assign rem_next = rem_q - LENGTH_W'(size);
	assign cut      = (rem_next != '0) && (cnt_q == CHUNK_CNT_W'(MAX_CHUNKS - 1));
	assign last     = (rem_next == '0) || cut;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = req_offset[OFFSET_W-1:KIB_SHIFT];
		div_req.divisor  = kib_eff;
		state_d          = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && req_length != '0) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV_OBJ;
				end
			end
			ST_DIV_OBJ: begin
				div_req.dividend = div_rsp.quotient;
				div_req.divisor  = KIB_W'(width_eff);
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV_TGT;
				end
			end
			ST_DIV_TGT: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit && last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kib_q   <= KIB_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STRIPE_KIB:   kib_q   <= cfg_wdata;
				REG_STRIPE_WIDTH: width_q <= cfg_wdata[WIDTH_W-1:0];
				default:          kib_q   <= kib_q;
			endcase
		end
	end

	srs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			lo_q  <= req_offset[KIB_SHIFT-1:0];
			len_q <= req_length;
			rem_q <= req_length;
			cnt_q <= '0;
		end
		if (state_q == ST_DIV_OBJ && div_rsp.done) begin
			obj_q <= OFFSET_W'(div_rsp.quotient);
			off_q <= {div_rsp.remainder[OBJ_OFF_W-KIB_SHIFT-1:0], lo_q};
		end
		if (state_q == ST_DIV_TGT && div_rsp.done) begin
			tgt_q <= div_rsp.remainder[TARGET_W-1:0];
		end
		if (emit) begin
			rem_q <= rem_next;
			cnt_q <= cnt_q + 1'b1;
			obj_q <= obj_q + 1'b1;
			off_q <= '0;
			tgt_q <= ({1'b0, tgt_q} == width_eff - 1'b1) ? '0 : tgt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obj_out_q  <= obj_q;
			off_out_q  <= off_q;
			size_out_q <= size;
			tgt_out_q  <= tgt_q;
			done_out_q <= len_q - rem_next;
			last_out_q <= last;
			cut_out_q  <= cut;
		end
	end

	assign out_valid        = out_valid_q;
	assign object_index     = obj_out_q;
	assign offset_in_object = off_out_q;
	assign chunk_bytes      = size_out_q;
	assign target_index     = tgt_out_q;
	assign bytes_done       = done_out_q;
	assign last_chunk       = last_out_q;
	assign truncated        = cut_out_q;

	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> last_chunk)
		else $error("truncated beat not marked last");

	a_chunk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_bytes != '0)
		else $error("empty chunk");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_OBJ || state_q == ST_DIV_TGT))
		else $error("divider finished outside a divide pass");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, target_index} < width_eff)
		else $error("target index beyond width");

endmodule

// ----- tb/stripe_request_splitter_top_tb.sv -----
`timescale 1ns / 1ps

module stripe_request_splitter_top_tb;
	import srs_pkg::*;

	typedef struct packed {
		logic [OFFSET_W-1:0]  obj;
		logic [OBJ_OFF_W-1:0] off;
		logic [CHUNK_W-1:0]   size;
		logic [TARGET_W-1:0]  tgt;
		logic [LENGTH_W-1:0]  done;
		logic                 last;
		logic                 cut;
	} chunk_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OFFSET_W-1:0]  req_offset = '0;
	logic [LENGTH_W-1:0]  req_length = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [OFFSET_W-1:0]  object_index;
	logic [OBJ_OFF_W-1:0] offset_in_object;
	logic [CHUNK_W-1:0]   chunk_bytes;
	logic [TARGET_W-1:0]  target_index;
	logic [LENGTH_W-1:0]  bytes_done;
	logic                 last_chunk;
	logic                 truncated;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = REG_STRIPE_KIB;
	logic [KIB_W-1:0]     cfg_wdata = '0;

	logic [KIB_W-1:0]     kib_cfg = KIB_RESET;
	logic [WIDTH_W-1:0]   width_cfg = WIDTH_RESET;
	chunk_t               pending_chunks[$];
	bit                   quiet = 1'b0;
	int                   pause_left = 0;
	int unsigned          mismatches = 0;
	int unsigned          n_requests = 0;
	int unsigned          n_chunks = 0;
	int unsigned          n_cut = 0;
	int unsigned          n_settings = 0;

	stripe_request_splitter_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_offset       (req_offset),
		.req_length       (req_length),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.object_index     (object_index),
		.offset_in_object (offset_in_object),
		.chunk_bytes      (chunk_bytes),
		.target_index     (target_index),
		.bytes_done       (bytes_done),
		.last_chunk       (last_chunk),
		.truncated        (truncated),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Timeout with %0d chunks outstanding", pending_chunks.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic longint unsigned stripe_bytes();
		longint unsigned k;
		k = kib_cfg;
		if (k == 0) k = 1;
		if (k > KIB_MAX) k = KIB_MAX;
		return k << KIB_SHIFT;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 200)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic split_request(input logic [OFFSET_W-1:0] offset,
			input logic [LENGTH_W-1:0] length);
		longint unsigned ssize, wdt, pos, stop, room, piece, obj;
		int n;
		chunk_t c;
		ssize = stripe_bytes();
		wdt = width_cfg;
		if (wdt == 0) wdt = 1;
		if (wdt > MAX_TARGETS) wdt = MAX_TARGETS;
		pos = offset;
		stop = pos + length;
		n = 0;
		while (pos < stop && n < MAX_CHUNKS) begin
			obj = pos / ssize;
			room = ssize - pos % ssize;
			piece = stop - pos;
			if (piece > room) piece = room;
			c.obj = obj[OFFSET_W-1:0];
			c.off = OBJ_OFF_W'(pos % ssize);
			c.size = CHUNK_W'(piece);
			c.tgt = TARGET_W'(obj % wdt);
			pos += piece;
			c.done = LENGTH_W'(pos - offset);
			c.cut = (pos < stop) && (n + 1 == MAX_CHUNKS);
			c.last = (pos >= stop) || c.cut;
			if (c.cut) n_cut++;
			pending_chunks.push_back(c);
			n++;
		end
	endtask

	task automatic check_chunk();
		chunk_t want;
		if (pending_chunks.size() == 0) begin
			note_mismatch("beat with no chunk pending", object_index, '0);
		end else begin
			want = pending_chunks.pop_front();
			if (object_index !== want.obj)
				note_mismatch("object_index", object_index, want.obj);
			if (offset_in_object !== want.off)
				note_mismatch("offset_in_object", offset_in_object, want.off);
			if (chunk_bytes !== want.size)
				note_mismatch("chunk_bytes", chunk_bytes, want.size);
			if (target_index !== want.tgt)
				note_mismatch("target_index", target_index, want.tgt);
			if (bytes_done !== want.done)
				note_mismatch("bytes_done", bytes_done, want.done);
			if (last_chunk !== want.last)
				note_mismatch("last_chunk", last_chunk, want.last);
			if (truncated !== want.cut)
				note_mismatch("truncated", truncated, want.cut);
		end
		n_chunks++;
		pause_left = quiet ? 0 : $urandom_range(0, 3);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) check_chunk();
		if (pause_left > 0) begin
			out_stall <= 1'b1;
			pause_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_request(input logic [OFFSET_W-1:0] offset,
			input logic [LENGTH_W-1:0] length);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_offset <= offset;
		req_length <= length;
		do @(posedge clk); while (in_stall !== 1'b0);
		split_request(offset, length);
		n_requests++;
	endtask

	// drop valid, drain the output, then give the divider time to go idle
	task automatic settle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_chunks.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [KIB_W-1:0] kib, input logic [WIDTH_W-1:0] width);
		cfg_we <= 1'b1;
		cfg_index <= REG_STRIPE_KIB;
		cfg_wdata <= kib;
		@(posedge clk);
		cfg_index <= REG_STRIPE_WIDTH;
		cfg_wdata <= {(KIB_W-WIDTH_W)'($urandom()), width};
		@(posedge clk);
		cfg_we <= 1'b0;
		kib_cfg = kib;
		width_cfg = width;
		n_settings++;
	endtask

	task automatic test_default_geometry();
		send_request(48'd0, 32'd1);
		send_request(48'd0, 32'd131072);
		send_request(48'd131071, 32'd2);
		send_request(48'd5, 32'd0);
		send_request(48'd393316, 32'd300000);
		settle();
	endtask

	task automatic test_field_extremes();
		send_request('1, 32'd1);
		send_request('1, '1);
		send_request('0, '1);
		send_request('1, '0);
		settle();
	endtask

	task automatic test_chunk_limit();
		set_geometry(21'd1, 5'd4);
		send_request(48'd0, 32'd65536);
		send_request(48'd0, 32'd65537);
		send_request(48'd512, 32'd65536);
		send_request(48'd1023, 32'd1);
		send_request(48'd1023, 32'd2);
		settle();
	endtask

	task automatic test_register_clamping();
		set_geometry(21'd0, 5'd0);
		send_request(48'd1000, 32'd5000);
		settle();
		set_geometry(KIB_MAX, 5'd16);
		send_request(48'h7FFF_BFFF_FFFB, 32'h8000_0000);
		send_request(48'd0, 32'h8000_0000);
		settle();
		set_geometry(21'h1F_FFFF, 5'd31);
		send_request(48'hFFFF_FFFF_FFFC, '1);
		settle();
		set_geometry(21'd2, 5'd17);
		send_request(48'd100, 32'd81920);
		settle();
	endtask

	task automatic test_random_traffic();
		logic [KIB_W-1:0]    kib;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic [63:0]         r64;
		longint unsigned     ssize, base, span;
		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 5))
				0: kib = KIB_W'($urandom_range(1, 8));
				1: kib = KIB_W'($urandom());
				2: kib = KIB_MAX;
				3: kib = '0;
				4: kib = KIB_W'($urandom_range(9, 4096));
				default: kib = KIB_W'($urandom_range(4097, 1048576));
			endcase
			if (phase == 0) kib = 21'd1;
			set_geometry(kib, WIDTH_W'($urandom_range(0, 31)));
			quiet = (phase == 2);
			ssize = stripe_bytes();
			span = ssize * 3;
			if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
			repeat (50) begin
				r64 = {$urandom(), $urandom()};
				case ($urandom_range(0, 9))
					0, 1: offset = r64[OFFSET_W-1:0];
					2: offset = '0;
					3: offset = '1;
					4, 5, 6: begin
						base = r64[OFFSET_W-1:0];
						base = base - base % ssize - 4 + $urandom_range(0, 8);
						offset = base[OFFSET_W-1:0];
					end
					default: begin
						base = $urandom_range(0, 3);
						base = base * ssize + $urandom() % ssize;
						offset = base[OFFSET_W-1:0];
					end
				endcase
				case ($urandom_range(0, 9))
					0: length = '0;
					1: length = $urandom();
					2: length = '1;
					3, 4, 5: length = $urandom_range(1, 32'(span));
					default: length = $urandom_range(1, 4096);
				endcase
				send_request(offset, length);
			end
			settle();
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_geometry();
		test_field_extremes();
		test_chunk_limit();
		test_register_clamping();
		test_random_traffic();
		settle();
		if (pending_chunks.size() != 0) begin
			$display("%0d chunks never arrived", pending_chunks.size());
			mismatches++;
		end
		$display("Split %0d requests under %0d stripe geometries into %0d chunks",
			n_requests, n_settings + 1, n_chunks);
		$display("%0d requests were cut short at the chunk limit", n_cut);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
